### sv/rag_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Rational accumulator package
// Command codes, field widths and the sequencer-to-unit control struct.
// ----------------------------------------------------------------------------
package rag_pkg;

  localparam int FIELD_W = 32;

  // Command codes carried in the input item.
  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_NORM = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  // Control struct for the shared divide unit: a start bit.
  typedef struct packed {
    logic start;
  } div_ctl_t;

endpackage : rag_pkg
`default_nettype wire

### sv/rag_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Rational accumulator divider
// Restoring unsigned divider, one quotient bit per cycle. Shared for the
// Euclidean remainders and for the final quotient divisions.
// ----------------------------------------------------------------------------
module rag_divider #(
  parameter int W = 32
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  rag_pkg::div_ctl_t    ctl,
  input  wire  [W-1:0]         dividend,
  input  wire  [W-1:0]         divisor,
  output logic                 done,
  output logic [W-1:0]         quotient,
  output logic [W-1:0]         remainder
);
  import rag_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;

  // One shift-and-subtract step per cycle.
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[W-1]};
    diff     = trial - {1'b0, d_r};
    if (ctl.start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

  // A finished division never coincides with a running one.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> busy_r) else $error("divider did not start");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0) else $error("divider count underrun");

endmodule : rag_divider
`default_nettype wire

### sv/rational_accumulator_gcd_reduce_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Rational accumulator with gcd reduction
// Holds one signed fraction; load, add and normalize commands.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_tready is low while it is worked on. An add
// computes its three products in turn on one multiplier, then the sum. Each
// reduction runs the shared one-bit-per-cycle divider: once per Euclidean
// remainder step (at most about 1.44*WORD_WIDTH steps, usually far fewer),
// then twice for the quotient divisions of numerator and denominator.
// The result waits in an output register while the next item is accepted
// once the sequencer is back in its idle state.
module rational_accumulator_gcd_reduce_unit #(
  parameter int WORD_WIDTH = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // tdata: operand_numerator[31:0], operand_denominator[63:32]
  input  wire  [63:0] in_tdata,
  // tuser: command[1:0]
  input  wire  [1:0]  in_tuser,
  output logic        out_tvalid,
  input  wire         out_tready,
  // tdata: result_numerator[31:0], result_denominator[63:32],
  //        value_valid[64], overflow[65], zero fill[71:66]
  output logic [71:0] out_tdata,
  input  wire         cfg_wr_en,
  input  wire         cfg_wr_data
);
  import rag_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int PW = 2 * W;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_SUM, S_RED, S_GCD, S_GCDW,
    S_QN, S_QNW, S_QD, S_QDW, S_OUT
  } state_t;

  state_t       state_r;
  logic         auto_r;
  logic [W-1:0] num_r, den_r;
  logic [W-1:0] on_r, od_r;
  logic [W-1:0] p1_r, p2_r;
  logic [W-1:0] a_r, b_r, g_r;
  logic         ovf_r;
  logic         nneg_r, dneg_r;
  logic         norm_r;
  logic         ovalid_r;
  logic [71:0]  odata_r;

  // Operand conversion from the 32-bit field to the word.
  function automatic logic [W-1:0] from_field(input logic [31:0] v);
    logic [PW+31:0] x;
    x = {{PW{v[31]}}, v};
    return x[W-1:0];
  endfunction
  function automatic logic fits(input logic [31:0] v);
    logic [PW+31:0] x, y;
    x = {{PW{v[31]}}, v};
    y = {{(PW+32){x[W-1]}}};
    y[W-1:0] = x[W-1:0];
    return x == y;
  endfunction
  function automatic logic [W-1:0] mag(input logic [W-1:0] x);
    return x[W-1] ? (~x + 1'b1) : x;
  endfunction
  function automatic logic [31:0] to_field(input logic [W-1:0] x);
    logic [PW+31:0] e;
    e = {{(PW+32){x[W-1]}}};
    e[W-1:0] = x;
    return e[31:0];
  endfunction

  // Shared multiplier: one product per cycle, registered.
  logic [W-1:0] ma, mb;
  logic [PW-1:0] prod;
  logic [PW-1:0] prod_w;
  logic         mul_ovf;
  logic         mneg;
  always_comb begin
    ma = num_r; mb = od_r;
    case (state_r)
      S_MUL1:  begin ma = num_r; mb = od_r; end
      S_MUL2:  begin ma = on_r;  mb = den_r; end
      S_MUL3:  begin ma = den_r; mb = od_r; end
      default: begin ma = num_r; mb = od_r; end
    endcase
    mneg   = ma[W-1] ^ mb[W-1];
    prod   = mag(ma) * mag(mb);
    prod_w = mneg ? PW'(~prod + 1'b1) : prod;
    mul_ovf = mneg ? (prod > PW'({1'b1, {(W-1){1'b0}}}))
                   : (prod > PW'({1'b0, {(W-1){1'b1}}}));
  end
  logic [W-1:0] prod_lo;
  assign prod_lo = prod_w[W-1:0];

  // Shared divider.
  div_ctl_t     dctl;
  logic [W-1:0] dvd, dvs, dq, dr;
  logic         ddone;
  rag_divider #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .ctl(dctl), .dividend(dvd), .divisor(dvs),
    .done(ddone), .quotient(dq), .remainder(dr)
  );
  always_comb begin
    dctl.start = (state_r == S_GCD) || (state_r == S_QN) || (state_r == S_QD);
    case (state_r)
      S_GCD:   begin dvd = a_r;        dvs = b_r; end
      S_QN:    begin dvd = mag(num_r); dvs = g_r; end
      S_QD:    begin dvd = mag(den_r); dvs = g_r; end
      default: begin dvd = a_r;        dvs = b_r; end
    endcase
  end

  logic [W-1:0] sum;
  logic         sum_ovf;
  assign sum     = p1_r + p2_r;
  assign sum_ovf = (p1_r[W-1] == p2_r[W-1]) && (sum[W-1] != p1_r[W-1]);

  logic [W-1:0] smin;
  assign smin = {1'b1, {(W-1){1'b0}}};

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  // Sequencer with state and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      auto_r   <= 1'b1;
      num_r    <= '0;
      den_r    <= '0;
      ovalid_r <= 1'b0;
      ovf_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) auto_r <= cfg_wr_data;
      if (ovalid_r && out_tready && state_r != S_OUT) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            on_r  <= from_field(in_tdata[31:0]);
            od_r  <= from_field(in_tdata[63:32]);
            ovf_r <= 1'b0;
            norm_r <= auto_r;
            case (cmd_t'(in_tuser))
              CMD_LOAD: begin
                num_r <= from_field(in_tdata[31:0]);
                den_r <= from_field(in_tdata[63:32]);
                ovf_r <= !fits(in_tdata[31:0]) || !fits(in_tdata[63:32]);
                state_r <= auto_r ? S_RED : S_OUT;
              end
              CMD_ADD: begin
                ovf_r <= !fits(in_tdata[31:0]) || !fits(in_tdata[63:32]);
                state_r <= S_MUL1;
              end
              CMD_NORM: state_r <= S_RED;
              default:  state_r <= S_OUT;
            endcase
          end
        end
        S_MUL1: begin
          p1_r <= prod_lo; ovf_r <= ovf_r | mul_ovf; state_r <= S_MUL2;
        end
        S_MUL2: begin
          p2_r <= prod_lo; ovf_r <= ovf_r | mul_ovf; state_r <= S_MUL3;
        end
        S_MUL3: begin
          den_r <= prod_lo; ovf_r <= ovf_r | mul_ovf; state_r <= S_SUM;
        end
        S_SUM: begin
          num_r <= sum; ovf_r <= ovf_r | sum_ovf;
          state_r <= norm_r ? S_RED : S_OUT;
        end
        S_RED: begin
          if (den_r == '0) begin
            state_r <= S_OUT;
          end else begin
            if (den_r[W-1]) begin
              num_r <= ~num_r + 1'b1;
              den_r <= ~den_r + 1'b1;
              ovf_r <= ovf_r | (num_r == smin) | (den_r == smin);
              a_r   <= mag(~den_r + 1'b1);
              b_r   <= mag(~num_r + 1'b1);
            end else begin
              a_r <= mag(den_r);
              b_r <= mag(num_r);
            end
            state_r <= S_GCD;
          end
        end
        S_GCD: begin
          if (b_r == '0) begin
            g_r     <= a_r;
            state_r <= S_QN;
          end else begin
            state_r <= S_GCDW;
          end
        end
        S_GCDW: begin
          if (ddone) begin
            a_r     <= b_r;
            b_r     <= dr;
            state_r <= S_GCD;
          end
        end
        S_QN: begin
          nneg_r  <= num_r[W-1];
          state_r <= S_QNW;
        end
        S_QNW: begin
          if (ddone) begin
            num_r   <= nneg_r ? (~dq + 1'b1) : dq;
            state_r <= S_QD;
          end
        end
        S_QD: begin
          dneg_r  <= den_r[W-1];
          state_r <= S_QDW;
        end
        S_QDW: begin
          if (ddone) begin
            den_r   <= dneg_r ? (~dq + 1'b1) : dq;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!ovalid_r || out_tready) begin
            odata_r  <= {6'b0, ovf_r, den_r != '0, to_field(den_r), to_field(num_r)};
            ovalid_r <= 1'b1;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The unit takes no item while it is working on one.
  a_busy_no_in: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_tready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_valid_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[63:32] != 32'd0 |-> out_tdata[64])
    else $error("valid flag mismatch");

endmodule : rational_accumulator_gcd_reduce_unit
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rational accumulator testbench
// Drives load, add, normalize and unused commands through the input stream,
// predicts the stored fraction and overflow flag per item, and compares every
// result item field by field under random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  import rag_pkg::*;

  localparam int LIMIT = 200000;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] num;
    logic [31:0] den;
  } op_item_t;

  typedef struct {
    logic [31:0] num;
    logic [31:0] den;
    logic        valid;
    logic        ovf;
  } frac_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic        cfg_wr_en;
  logic        cfg_wr_data;

  // Predictor state: stored fraction and reduction setting.
  logic [31:0] acc_num;
  logic [31:0] acc_den;
  logic        auto_reduce;
  logic        step_ovf;

  op_item_t   pending_ops[$];
  frac_item_t expected_fracs[$];

  int  send_idle_pct;
  int  recv_idle_pct;
  int  errors;
  int  stall_cycles;
  int  n_accepted;
  int  n_checked;
  bit  hold_sender;

  rational_accumulator_gcd_reduce_unit #(.WORD_WIDTH(32)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] mag32(logic [31:0] x);
    return x[31] ? -x : x;
  endfunction

  function automatic logic [31:0] neg_chk(logic [31:0] x);
    if (x == 32'h8000_0000) step_ovf = 1'b1;
    return -x;
  endfunction

  function automatic logic [31:0] mul_chk(logic [31:0] a, logic [31:0] b);
    logic signed [63:0] full;
    full = $signed(a) * $signed(b);
    if (full != {{32{full[31]}}, full[31:0]}) step_ovf = 1'b1;
    return full[31:0];
  endfunction

  function automatic logic [31:0] add_chk(logic [31:0] a, logic [31:0] b);
    logic [31:0] s;
    s = a + b;
    if (a[31] == b[31] && s[31] != a[31]) step_ovf = 1'b1;
    return s;
  endfunction

  function automatic logic [31:0] div_signed_mag(logic [31:0] x, logic [31:0] g);
    logic [31:0] q;
    q = mag32(x) / g;
    return x[31] ? -q : q;
  endfunction

  // Sign into the numerator, then divide both parts by the magnitude gcd.
  function automatic void reduce_fraction();
    logic [31:0] a, b, t;
    if (acc_den == 0) return;
    if (acc_den[31]) begin
      acc_num = neg_chk(acc_num);
      acc_den = neg_chk(acc_den);
    end
    a = mag32(acc_den);
    b = mag32(acc_num);
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    acc_num = div_signed_mag(acc_num, a);
    acc_den = div_signed_mag(acc_den, a);
  endfunction

  function automatic frac_item_t accumulate_fraction(op_item_t op);
    frac_item_t r;
    logic [31:0] p1, p2;
    step_ovf = 1'b0;
    case (op.cmd)
      CMD_LOAD: begin
        acc_num = op.num;
        acc_den = op.den;
        if (auto_reduce) reduce_fraction();
      end
      CMD_ADD: begin
        p1 = mul_chk(acc_num, op.den);
        p2 = mul_chk(op.num, acc_den);
        acc_num = add_chk(p1, p2);
        acc_den = mul_chk(acc_den, op.den);
        if (auto_reduce) reduce_fraction();
      end
      CMD_NORM: reduce_fraction();
      default: ;
    endcase
    r.num = acc_num;
    r.den = acc_den;
    r.valid = (acc_den != 0);
    r.ovf = step_ovf;
    return r;
  endfunction

  // Driver: present queued items, with random gaps between them.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_ops.size() > 0 && !hold_sender &&
          $urandom_range(99) >= send_idle_pct) begin
        op_item_t op;
        op = pending_ops.pop_front();
        expected_fracs.push_back(accumulate_fraction(op));
        in_tvalid <= 1'b1;
        in_tuser <= op.cmd;
        in_tdata <= {op.den, op.num};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) n_accepted <= n_accepted + 1;
  end

  // Monitor: compare each result item with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_fracs.size() == 0) begin
          $error("result item with no expectation: %h", out_tdata);
          errors++;
        end else begin
          frac_item_t e;
          e = expected_fracs.pop_front();
          if (out_tdata[31:0] !== e.num) begin
            $error("result_numerator exp %h got %h", e.num, out_tdata[31:0]);
            errors++;
          end
          if (out_tdata[63:32] !== e.den) begin
            $error("result_denominator exp %h got %h", e.den, out_tdata[63:32]);
            errors++;
          end
          if (out_tdata[64] !== e.valid) begin
            $error("value_valid exp %b got %b", e.valid, out_tdata[64]);
            errors++;
          end
          if (out_tdata[65] !== e.ovf) begin
            $error("overflow exp %b got %b", e.ovf, out_tdata[65]);
            errors++;
          end
        end
        n_checked++;
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles with no accepted item on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(int'($urandom_range(20)) - 10);
      3: return 32'(int'($urandom_range(2000)) - 1000);
      4: return 32'hFFFF_FFFF;
      5: return 32'($urandom_range(65535)) << $urandom_range(16);
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_op(cmd_t c, logic [31:0] n, logic [31:0] d);
    op_item_t op;
    op.cmd = c;
    op.num = n;
    op.den = d;
    pending_ops.push_back(op);
  endtask

  task automatic drain();
    while (pending_ops.size() > 0 || expected_fracs.size() > 0) @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  // Random phase: mostly small well-behaved fractions so that adds stay
  // in range and reductions have real work; some full-range noise.
  task automatic queue_random(int count);
    cmd_t c;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0, 1, 2: c = CMD_LOAD;
        3, 4, 5, 6: c = CMD_ADD;
        7, 8: c = CMD_NORM;
        default: c = CMD_NOP;
      endcase
      if ($urandom_range(3) != 0)
        queue_op(c, 32'(int'($urandom_range(200)) - 100),
                 32'(int'($urandom_range(60)) - 30));
      else
        queue_op(c, rand_word(), rand_word());
    end
  endtask

  task automatic write_auto_reduce(logic v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    auto_reduce = v;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    acc_num = '0;
    acc_den = '0;
    auto_reduce = 1'b1;
    errors = 0;
    stall_cycles = 0;
    n_accepted = 0;
    n_checked = 0;
    hold_sender = 0;
    send_idle_pct = 30;
    recv_idle_pct = 60;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: invalid start, extremes, sign handling, unused command.
    queue_op(CMD_NORM, '0, '0);
    queue_op(CMD_ADD, 32'd1, 32'd2);
    queue_op(CMD_LOAD, 32'd6, 32'hFFFF_FFFC);
    queue_op(CMD_ADD, 32'd1, 32'd3);
    queue_op(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_op(CMD_LOAD, 32'd5, 32'h8000_0000);
    queue_op(CMD_LOAD, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_op(CMD_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_op(CMD_ADD, 32'h7FFF_FFFF, 32'd1);
    queue_op(CMD_LOAD, 32'h8000_0000, 32'h8000_0000);
    queue_op(CMD_LOAD, 32'd0, 32'd7);
    queue_op(CMD_ADD, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_op(CMD_LOAD, 32'd12, 32'd0);
    queue_op(CMD_NORM, '0, '0);
    queue_op(CMD_ADD, 32'd3, 32'd4);
    drain();

    // Loads and adds with reduction off, explicit normalizes, then random items.
    write_auto_reduce(1'b0);
    queue_op(CMD_LOAD, 32'd6, 32'hFFFF_FFF7);
    queue_op(CMD_ADD, 32'd2, 32'd3);
    queue_op(CMD_NORM, '0, '0);
    queue_op(CMD_LOAD, 32'h8000_0000, 32'h8000_0000);
    queue_op(CMD_NORM, '0, '0);
    queue_random(300);
    // Sender holds off until every expected result has come.
    while (pending_ops.size() > 0) @(posedge clk);
    hold_sender = 1;
    while (expected_fracs.size() > 0) @(posedge clk);
    hold_sender = 0;
    drain();

    write_auto_reduce(1'b1);
    send_idle_pct = 60;
    recv_idle_pct = 30;
    queue_random(450);
    drain();

    write_auto_reduce(1'b0);
    queue_random(100);
    drain();
    write_auto_reduce(1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(350);
    drain();

    $display("Ran %0d items (%0d results checked) over load, add, normalize and", n_accepted,
             n_checked);
    $display("unused commands, with reduction on and off and field extremes.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

### rational_accumulator_gcd_reduce_unit.f
sv/rag_pkg.sv
sv/rag_divider.sv
sv/rational_accumulator_gcd_reduce_unit.sv
dv/tb.sv
